FILE: rtl/bssc_pkg.sv
// Shared constants for the baud scale and select calculator.
// Used by bssc_div, baud_scale_select_calc and tb_top; depends on nothing else.

package bssc_pkg;

	// Field widths
	localparam int CLOCK_W  = 28;
	localparam int BAUD_W   = 32;
	localparam int SCALE_W  = 4;
	localparam int SELECT_W = 12;

	// A valid rate never exceeds clock / 16, so it fits in 24 bits.
	localparam int RATE_W   = 24;
	// The ratio clock / (2 * rate) stays below 2^27.
	localparam int RATIO_W  = 27;
	// The search limit peaks just under 2^22.
	localparam int LIMIT_W  = 24;
	// Numerator and divisor width of the shared divider.
	localparam int DIV_W    = 36;

	localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(32000000);
	localparam logic [LIMIT_W-1:0] LIMIT_START = LIMIT_W'(255);

	// Rate bounds as right shifts of the clock: 16 and 2 * 4194304.
	localparam int RATE_HI_SHIFT = 4;
	localparam int RATE_LO_SHIFT = 23;

	// Scale search range
	localparam logic signed [SCALE_W-1:0] SCALE_MIN  = -4'sd7;
	localparam logic signed [SCALE_W-1:0] SCALE_LAST = 4'sd6;
	localparam logic signed [SCALE_W-1:0] SCALE_END  = 4'sd7;
	// Below this scale the limit shifts in a one.
	localparam logic signed [SCALE_W-1:0] SCALE_FILL = -4'sd3;

endpackage

FILE: rtl/bssc_div.sv
// Restoring unsigned divider, one quotient bit per clock.
// Depends on bssc_pkg for the default width.

module bssc_div #(
	parameter int WIDTH = bssc_pkg::DIV_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] numer,
	input  logic [WIDTH-1:0] denom,
	output logic             done,
	output logic [WIDTH-1:0] quot
);
	import bssc_pkg::*;

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH+1:0] diff;
	logic             fits;

	// Shift in the next numerator bit and try to subtract the divisor.
	always_comb begin
		trial = {rem_q, quo_q[WIDTH-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		fits  = ~diff[WIDTH+1];
	end

	// Control: bit counter and completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= numer;
			den_q <= denom;
		end else if (run_q) begin
			rem_q <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

FILE: rtl/baud_scale_select_calc.sv
// Top level of the baud scale and select calculator.
// Depends on bssc_pkg and instantiates the shared divider bssc_div.
//
// Usage: a requested rate is taken on start while busy is low. The block
// checks it against the clock register, divides the clock by twice the
// rate, searches the scale from -7 upward, then divides once more to get
// the rounded divider. One result comes back per request, on baud_scale,
// baud_select and rate_error, shown for exactly one cycle with done high.
// A rejected rate (zero, above clock/16, below clock/8388608) returns its
// error result in the cycle after the transfer. For a valid rate done rises
// after two passes through the one-bit-per-clock divider, the scale search
// and the sequencer's own steps. The next request may be given in
// the cycle that done is high. The clock register is written over the
// cfg channel, ready while idle and no request is offered.
// Reset sets the clock register to 32 MHz and returns the sequencer to
// idle; results have no back-pressure, so the receiver cannot stall.

module baud_scale_select_calc (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [bssc_pkg::BAUD_W-1:0]          requested_baud,
	output logic                                 done,
	output logic signed [bssc_pkg::SCALE_W-1:0]  baud_scale,
	output logic [bssc_pkg::SELECT_W-1:0]        baud_select,
	output logic                                 rate_error,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bssc_pkg::CLOCK_W-1:0]         cfg_data
);
	import bssc_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV1   = 3'd1;
	localparam logic [2:0] ST_SEARCH = 3'd2;
	localparam logic [2:0] ST_SETUP  = 3'd3;
	localparam logic [2:0] ST_DIV2   = 3'd4;

	logic [2:0]                 state_q;
	logic [CLOCK_W-1:0]         clock_q;
	logic [RATE_W-1:0]          baud_q;
	logic [RATIO_W-1:0]         ratio_q;
	logic [LIMIT_W-1:0]         limit_q;
	logic signed [SCALE_W-1:0]  scale_q;
	logic                       done_q;
	logic signed [SCALE_W-1:0]  scale_out_q;
	logic [SELECT_W-1:0]        select_q;
	logic                       error_q;

	logic                       accept;
	logic                       rate_bad;
	logic [BAUD_W-1:0]          rate_ceil;
	logic [BAUD_W-1:0]          rate_floor;

	logic                       div_start;
	logic [DIV_W-1:0]           div_num;
	logic [DIV_W-1:0]           div_den;
	logic                       div_done;
	logic [DIV_W-1:0]           div_quot;

	logic [DIV_W-1:0]           b2;
	logic [DIV_W-1:0]           c_ext;
	logic [DIV_W-1:0]           d_shift;
	logic [SCALE_W-1:0]         sh_up;
	logic [SCALE_W-1:0]         sh_c;

	// A clock write never lands in the same cycle as a request transfer.
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = ~busy & ~start;
	assign accept    = start & ~busy;

	// Range check of the incoming rate.
	always_comb begin
		rate_ceil  = BAUD_W'(clock_q >> RATE_HI_SHIFT);
		rate_floor = BAUD_W'(clock_q >> RATE_LO_SHIFT);
		rate_bad   = (requested_baud == '0) || (requested_baud > rate_ceil)
			|| (requested_baud < rate_floor);
	end

	// Operands for the second division, chosen by the scale.
	always_comb begin
		b2      = DIV_W'({baud_q, 1'b0});
		c_ext   = DIV_W'(clock_q - {baud_q, 4'b0000});
		sh_up   = SCALE_W'(scale_q + 4'sd3);
		sh_c    = SCALE_W'(-scale_q - 4'sd3);
		d_shift = b2 << sh_up;
	end

	// Divider operand selection and launch.
	always_comb begin
		div_start = 1'b0;
		div_num   = DIV_W'(clock_q);
		div_den   = DIV_W'({requested_baud[RATE_W-1:0], 1'b0});
		if (state_q == ST_IDLE) begin
			div_start = accept & ~rate_bad;
		end else if (state_q == ST_SETUP) begin
			div_start = 1'b1;
			if (scale_q <= SCALE_FILL) begin
				div_num = (c_ext << sh_c) + DIV_W'(baud_q);
				div_den = b2;
			end else if (scale_q[SCALE_W-1]) begin
				div_num = c_ext + (d_shift >> 1);
				div_den = d_shift;
			end else begin
				div_num = DIV_W'(clock_q) + (d_shift >> 1);
				div_den = d_shift;
			end
		end
	end

	bssc_div #(
		.WIDTH(DIV_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (div_num),
		.denom (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	// Clock register, written over the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= CLOCK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			clock_q <= cfg_data;
		end
	end

	// Sequencer: first division, scale search, second division, result; a rejected rate goes straight to the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (rate_bad) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_DIV1;
						end
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if ((LIMIT_W'(ratio_q) < limit_q) && (ratio_q[RATIO_W-1:LIMIT_W] == '0)) begin
						state_q <= ST_SETUP;
					end else if (scale_q == SCALE_LAST) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the search and the result registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			baud_q      <= requested_baud[RATE_W-1:0];
			scale_out_q <= '0;
			select_q    <= '0;
			error_q     <= rate_bad;
		end
		if (state_q == ST_DIV1 && div_done) begin
			ratio_q <= div_quot[RATIO_W-1:0];
			limit_q <= LIMIT_START;
			scale_q <= SCALE_MIN;
		end
		if (state_q == ST_SEARCH) begin
			if (!((LIMIT_W'(ratio_q) < limit_q) && (ratio_q[RATIO_W-1:LIMIT_W] == '0))) begin
				limit_q <= {limit_q[LIMIT_W-2:0], (scale_q < SCALE_FILL)};
				scale_q <= (scale_q == SCALE_LAST) ? SCALE_END : scale_q + 4'sd1;
			end
		end
		if (state_q == ST_DIV2 && div_done) begin
			scale_out_q <= scale_q;
			error_q     <= 1'b0;
			if (scale_q[SCALE_W-1]) begin
				select_q <= div_quot[SELECT_W-1:0];
			end else begin
				select_q <= div_quot[SELECT_W-1:0] - SELECT_W'(1);
			end
		end
	end

	assign done        = done_q;
	assign baud_scale  = scale_out_q;
	assign baud_select = select_q;
	assign rate_error  = error_q;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for baud_scale_select_calc: drives rate requests and clock writes.
// Depends on bssc_pkg, bssc_div and the baud_scale_select_calc RTL; needs no other files.

module tb_top;
	import bssc_pkg::*;

	// One computed setting as it appears on the result ports.
	typedef struct packed {
		logic [SCALE_W-1:0]  scale;
		logic [SELECT_W-1:0] select;
		logic                rate_err;
	} baud_setting_t;

	localparam baud_setting_t REJECTED = '{scale: '0, select: '0, rate_err: 1'b1};
	localparam int OVERSAMPLE     = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIRECTED_ROWS  = 24;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 65;
	localparam int CALM_AFTER     = 550;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                start          = 1'b0;
	logic                busy;
	logic [BAUD_W-1:0]   requested_baud = '0;
	logic                done;
	logic [SCALE_W-1:0]  baud_scale;
	logic [SELECT_W-1:0] baud_select;
	logic                rate_error;
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	logic [CLOCK_W-1:0]  cfg_data       = '0;

	// Marks a request whose result is typed in rather than predicted.
	logic                expect_reject  = 1'b0;

	baud_setting_t       pending_settings[$];
	baud_setting_t       oldest;
	logic [CLOCK_W-1:0]  shadow_clock   = CLOCK_RESET;
	int                  mismatches     = 0;
	int                  stall_cycles   = 0;

	// Directed rows at the reset clock of 32 MHz; rejected rows carry a typed result.
	logic [BAUD_W-1:0] dir_rates [DIRECTED_ROWS] = '{
		32'd0, 32'hFFFFFFFF, 32'd2000001, 32'd2, 32'd1,
		32'd2000000, 32'd3, 32'd7, 32'd9600, 32'd19200,
		32'd38400, 32'd57600, 32'd115200, 32'd230400, 32'd460800,
		32'd921600, 32'd1000000, 32'd1500000, 32'd4800, 32'd2400,
		32'd1200, 32'd300, 32'd100, 32'd50
	};
	bit dir_rejected [DIRECTED_ROWS] = '{
		1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0
	};

	baud_scale_select_calc i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.requested_baud (requested_baud),
		.done           (done),
		.baud_scale     (baud_scale),
		.baud_select    (baud_select),
		.rate_error     (rate_error),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Computes the scale and divider that a clock and a requested rate call for.
	function automatic baud_setting_t predict_setting(input logic [CLOCK_W-1:0] clock_val,
			input logic [BAUD_W-1:0] rate);
		logic [63:0]   clk64;
		logic [63:0]   twice;
		logic [63:0]   ratio;
		logic [63:0]   limit;
		logic [63:0]   excess;
		logic [63:0]   divider;
		int            scale;
		baud_setting_t res;
		clk64 = 64'(clock_val);
		res = '0;
		if (rate == 0 || 64'(rate) > (clk64 >> RATE_HI_SHIFT) ||
				64'(rate) < (clk64 >> RATE_LO_SHIFT)) begin
			res.rate_err = 1'b1;
			return res;
		end
		twice = 64'(rate) * 2;
		ratio = clk64 / twice;
		limit = 64'(LIMIT_START);
		scale = int'(SCALE_MIN);
		// Widen the limit until the ratio fits below it or the range runs out.
		while (scale < int'(SCALE_END) && ratio >= limit) begin
			limit = limit << 1;
			if (scale < int'(SCALE_FILL))
				limit = limit | 64'd1;
			scale++;
		end
		if (scale < 0) begin
			excess = clk64 - OVERSAMPLE * twice;
			if (scale <= int'(SCALE_FILL)) begin
				divider = ((excess << (-scale - 3)) + twice / 2) / twice;
			end else begin
				twice = twice << (scale + 3);
				divider = (excess + twice / 2) / twice;
			end
		end else begin
			twice = twice << (scale + 3);
			divider = (clk64 + twice / 2) / twice - 1;
		end
		res.scale  = scale[SCALE_W-1:0];
		res.select = divider[SELECT_W-1:0];
		return res;
	endfunction

	// Picks a rate: mostly in range and spread over all scales, the rest edges and noise.
	function automatic logic [BAUD_W-1:0] pick_rate(input logic [CLOCK_W-1:0] clock_val);
		logic [BAUD_W-1:0] lo;
		logic [BAUD_W-1:0] hi;
		logic [BAUD_W-1:0] r;
		int                pick;
		hi = BAUD_W'(clock_val >> RATE_HI_SHIFT);
		lo = BAUD_W'(clock_val >> RATE_LO_SHIFT);
		if (lo == 0)
			lo = 1;
		pick = $urandom_range(0, 99);
		if (hi < lo)
			return (pick < 50) ? BAUD_W'($urandom_range(0, 20)) : BAUD_W'($urandom);
		if (pick < 25)
			return lo + ($urandom % (hi - lo + 1));
		if (pick < 65) begin
			r = hi >> $urandom_range(0, 22);
			r = r + ($urandom % (r / 2 + 1));
			if (r < lo)
				r = lo;
			if (r > hi)
				r = hi;
			return r;
		end
		if (pick < 80) begin
			case ($urandom_range(0, 4))
				0: return lo;
				1: return hi;
				2: return hi + 1;
				3: return lo - 1;
				default: return '0;
			endcase
		end
		return BAUD_W'($urandom);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Offers one request until it transfers, then idles now and then.
	task automatic send_rate(input logic [BAUD_W-1:0] rate, input bit typed_reject,
			input bit idle_ok);
		start          <= 1'b1;
		requested_baud <= rate;
		expect_reject  <= typed_reject;
		do @(posedge clk); while (busy);
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Waits for every pending result, then writes the clock register.
	task automatic set_clock(input logic [CLOCK_W-1:0] value);
		do @(posedge clk); while (pending_settings.size() != 0);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Records expectations at each request transfer and checks each result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_settings.size() == 0) begin
					report_mismatch("result with nothing pending", int'(baud_select), 0);
				end else begin
					oldest = pending_settings.pop_front();
					if (baud_scale !== oldest.scale)
						report_mismatch("baud_scale", int'(baud_scale),
							int'(oldest.scale));
					if (baud_select !== oldest.select)
						report_mismatch("baud_select", int'(baud_select),
							int'(oldest.select));
					if (rate_error !== oldest.rate_err)
						report_mismatch("rate_error", int'(rate_error),
							int'(oldest.rate_err));
				end
			end
			if (start && !busy)
				pending_settings.push_back(expect_reject ? REJECTED :
					predict_setting(shadow_clock, requested_baud));
			if (cfg_valid && cfg_ready)
				shadow_clock = cfg_data;
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Ends a run that stops making progress.
	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [CLOCK_W-1:0] clock_plan [PHASES];
		int                 i;
		int                 phase;
		int                 n;
		int                 total;
		clock_plan = '{28'd1, 28'd0, 28'hFFFFFFF, 28'd200000000, 28'd16000000,
			28'd1843200, 28'd0, 28'd0, 28'd0, 28'd0};
		for (i = 6; i < PHASES; i++)
			clock_plan[i] = CLOCK_W'($urandom_range(1, 200000000));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset clock.
		for (i = 0; i < DIRECTED_ROWS; i++)
			send_rate(dir_rates[i], dir_rejected[i], 1'b1);
		start <= 1'b0;

		// Random requests, one clock setting per phase.
		total = 0;
		for (phase = 0; phase < PHASES; phase++) begin
			set_clock(clock_plan[phase]);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_rate(pick_rate(clock_plan[phase]), 1'b0, total < CALM_AFTER);
				total++;
				// Hold off once mid-phase until every result has come back.
				if (phase == 4 && n == 30) begin
					start <= 1'b0;
					do @(posedge clk); while (pending_settings.size() != 0);
				end
			end
			start <= 1'b0;
		end

		do @(posedge clk); while (pending_settings.size() != 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/bssc_pkg.sv
rtl/bssc_div.sv
rtl/baud_scale_select_calc.sv
bench/tb_top.sv
